FILE: src/cor_pkg.sv
`default_nettype none

package cor_pkg;

    // Default field widths
    localparam int COORD_BITS_DEF  = 16;
    localparam int RADIUS_BITS_DEF = 12;
    localparam int MODE_BITS       = 2;
    localparam int COLOR_BITS      = 32;

    // Request kinds carried on tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Drawing modes; the fourth code draws a full circle
    localparam logic [MODE_BITS-1:0] MODE_FULL  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_UPPER = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LOWER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_ROOT,
        ST_OUT
    } state_t;

    // Which signed step coordinate feeds one axis of a point
    typedef enum logic [1:0] {
        SEL_POS_X,
        SEL_NEG_X,
        SEL_POS_Y,
        SEL_NEG_Y
    } sel_t;

    typedef struct packed {
        sel_t dx;
        sel_t dy;
    } offset_sel_t;

    // Index of the final point in one step
    function automatic logic [2:0] last_index(input logic [MODE_BITS-1:0] mode);
        logic [2:0] idx;
        begin
            idx = ((mode == MODE_UPPER) || (mode == MODE_LOWER)) ? 3'd3 : 3'd7;
            return idx;
        end
    endfunction

    // Symmetry table: offset of each point of a step
    function automatic offset_sel_t offset_sel(input logic [MODE_BITS-1:0] mode,
                                               input logic [2:0] idx);
        offset_sel_t s;
        begin
            s = '{dx: SEL_POS_X, dy: SEL_POS_Y};
            unique case (mode)
                MODE_UPPER: begin
                    unique case (idx[1:0])
                        2'd0:    s = '{dx: SEL_POS_Y, dy: SEL_NEG_X};
                        2'd1:    s = '{dx: SEL_NEG_Y, dy: SEL_NEG_X};
                        2'd2:    s = '{dx: SEL_POS_X, dy: SEL_NEG_Y};
                        default: s = '{dx: SEL_NEG_X, dy: SEL_NEG_Y};
                    endcase
                end
                MODE_LOWER: begin
                    unique case (idx[1:0])
                        2'd0:    s = '{dx: SEL_POS_Y, dy: SEL_POS_X};
                        2'd1:    s = '{dx: SEL_NEG_Y, dy: SEL_POS_X};
                        2'd2:    s = '{dx: SEL_POS_X, dy: SEL_POS_Y};
                        default: s = '{dx: SEL_NEG_X, dy: SEL_POS_Y};
                    endcase
                end
                default: begin
                    unique case (idx)
                        3'd0:    s = '{dx: SEL_POS_X, dy: SEL_POS_Y};
                        3'd1:    s = '{dx: SEL_NEG_X, dy: SEL_POS_Y};
                        3'd2:    s = '{dx: SEL_POS_X, dy: SEL_NEG_Y};
                        3'd3:    s = '{dx: SEL_NEG_X, dy: SEL_NEG_Y};
                        3'd4:    s = '{dx: SEL_POS_Y, dy: SEL_POS_X};
                        3'd5:    s = '{dx: SEL_NEG_Y, dy: SEL_POS_X};
                        3'd6:    s = '{dx: SEL_POS_Y, dy: SEL_NEG_X};
                        default: s = '{dx: SEL_NEG_Y, dy: SEL_NEG_X};
                    endcase
                end
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/circle_outline_rasterizer_core.sv
`default_nettype none

// Circle outline rasterizer. A start request (tuser = start) loads the center, radius,
// mode and color and returns the first outline point; each next request returns one more
// point, with tlast on the final point of the shape. A next request with no shape open
// returns nothing and frees the input again. One request is worked at a time and
// s_tready is high only while idle; the result register lets the next request enter while
// a point still waits on the m_ side. With the result register free, a next request that
// is not the last point of a step passes through the check and output states into the
// result register, and the input opens again as the point enters it. A start request first
// squares the radius by a bit-serial shift-add, one multiplier bit a cycle. For the last
// point of a step the new y is found by a digit-serial square root that retires two
// remainder bits and one root bit a cycle. When r*r - x*x goes negative the root is
// skipped and that final point goes straight to the output state.
// A point that finds the result register still full waits until it drains.
module circle_outline_rasterizer_core #(
    parameter int COORD_BITS  = cor_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = cor_pkg::RADIUS_BITS_DEF,
    localparam int S_DATA_BITS =
        ((2 * COORD_BITS + RADIUS_BITS + cor_pkg::MODE_BITS + cor_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS =
        ((2 * (COORD_BITS + 1) + cor_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // request channel
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata: center_x, center_y, radius, arc_mode, color (from bit 0 up)
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    // s_tuser: operation
    input  wire logic                   s_tuser,
    // point channel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata: point_x, point_y, point_color (from bit 0 up)
    output logic [M_DATA_BITS-1:0]      m_tdata,
    output logic                        m_tlast
);
    import cor_pkg::*;

    localparam int CB        = COORD_BITS;
    localparam int RB        = RADIUS_BITS;
    localparam int OB        = CB + 1;
    localparam int STEP_BITS = RB + 1;
    localparam int SQ_BITS   = 2 * RB;
    localparam int REM_BITS  = 2 * RB + 1;
    localparam int PART_BITS = RB + 2;
    localparam int SUM_BITS  = ((CB > STEP_BITS) ? CB : STEP_BITS) + 2;
    localparam int CNT_BITS  = $clog2(RB);

    // Input field positions
    localparam int CY_LSB   = CB;
    localparam int R_LSB    = 2 * CB;
    localparam int MODE_LSB = R_LSB + RB;
    localparam int COL_LSB  = MODE_LSB + MODE_BITS;

    state_t state_reg, state_next;

    logic                       busy_reg, busy_next;
    logic signed [CB-1:0]       cx_reg, cx_next;
    logic signed [CB-1:0]       cy_reg, cy_next;
    logic [RB-1:0]              r_reg, r_next;
    logic [MODE_BITS-1:0]       mode_reg, mode_next;
    logic [COLOR_BITS-1:0]      color_reg, color_next;
    logic [STEP_BITS-1:0]       x_reg, x_next;
    logic [STEP_BITS-1:0]       y_reg, y_next;
    logic [2:0]                 idx_reg, idx_next;
    logic signed [REM_BITS-1:0] rem_reg, rem_next;
    logic [RB-1:0]              mplier_reg, mplier_next;
    logic [SQ_BITS-1:0]         rad_reg, rad_next;
    logic [PART_BITS-1:0]       part_reg, part_next;
    logic [RB-1:0]              root_reg, root_next;
    logic [CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic                       step_end_reg, step_end_next;
    logic                       neg_reg, neg_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_BITS-1:0]     m_tdata_reg, m_tdata_next;
    logic                       m_tlast_reg, m_tlast_next;

    logic                       s_accept;
    logic                       out_load;
    logic                       at_step_end;
    logic signed [REM_BITS-1:0] rem_sub;
    logic [PART_BITS+1:0]       root_shift;
    logic [PART_BITS+1:0]       root_trial;
    logic                       root_fits;
    logic [STEP_BITS-1:0]       x_inc;
    logic                       shape_last;
    offset_sel_t                sel;
    logic signed [SUM_BITS-1:0] x_s, y_s, cx_s, cy_s, dx_s, dy_s, px_s, py_s;

    assign s_accept = s_tvalid && s_tready;

    // Step arithmetic shared by the state machine and the datapath
    assign at_step_end = (idx_reg == last_index(mode_reg));
    assign rem_sub     = rem_reg - $signed(REM_BITS'({x_reg, 1'b1}));
    assign root_shift  = {2'b00, part_reg[PART_BITS-3:0], rad_reg[SQ_BITS-1 -: 2]};
    assign root_trial  = (PART_BITS + 2)'({root_reg, 2'b01});
    assign root_fits   = (root_shift >= root_trial);
    assign x_inc       = x_reg + STEP_BITS'(1);
    assign shape_last  = step_end_reg && (neg_reg || ({1'b0, root_reg} < x_inc));

    // Point position: center plus the selected signed step coordinate
    always_comb begin
        sel  = offset_sel(mode_reg, idx_reg);
        x_s  = $signed(SUM_BITS'(x_reg));
        y_s  = $signed(SUM_BITS'(y_reg));
        cx_s = SUM_BITS'(cx_reg);
        cy_s = SUM_BITS'(cy_reg);
        case (sel.dx)
            SEL_POS_X: dx_s = x_s;
            SEL_NEG_X: dx_s = -x_s;
            SEL_POS_Y: dx_s = y_s;
            default:   dx_s = -y_s;
        endcase
        case (sel.dy)
            SEL_POS_X: dy_s = x_s;
            SEL_NEG_X: dy_s = -x_s;
            SEL_POS_Y: dy_s = y_s;
            default:   dy_s = -y_s;
        endcase
        px_s = cx_s + dx_s;
        py_s = cy_s + dy_s;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == OP_START) ? ST_SQUARE : ST_CHECK;
                end
            end
            ST_SQUARE: begin
                if (cnt_reg == '0) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!busy_reg) begin
                    state_next = ST_IDLE;
                end else if (at_step_end && !rem_sub[REM_BITS-1]) begin
                    state_next = ST_ROOT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_ROOT: begin
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State machine outputs
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_OUT:  out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        busy_next     = busy_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        r_next        = r_reg;
        mode_next     = mode_reg;
        color_next    = color_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        mplier_next   = mplier_reg;
        rad_next      = rad_reg;
        part_next     = part_reg;
        root_next     = root_reg;
        cnt_next      = cnt_reg;
        step_end_next = step_end_reg;
        neg_next      = neg_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                // load a new shape and start squaring the radius
                if (s_accept && (s_tuser == OP_START)) begin
                    cx_next     = s_tdata[CB-1:0];
                    cy_next     = s_tdata[CY_LSB +: CB];
                    r_next      = s_tdata[R_LSB +: RB];
                    mode_next   = s_tdata[MODE_LSB +: MODE_BITS];
                    color_next  = s_tdata[COL_LSB +: COLOR_BITS];
                    x_next      = '0;
                    y_next      = STEP_BITS'(s_tdata[R_LSB +: RB]);
                    idx_next    = '0;
                    busy_next   = 1'b1;
                    rem_next    = '0;
                    mplier_next = s_tdata[R_LSB +: RB];
                    cnt_next    = CNT_BITS'(RB - 1);
                end
            end
            ST_SQUARE: begin
                // shift-add one multiplier bit, most significant first
                rem_next    = {rem_reg[REM_BITS-2:0], 1'b0}
                              + (mplier_reg[RB-1] ? $signed(REM_BITS'(r_reg)) : '0);
                mplier_next = {mplier_reg[RB-2:0], 1'b0};
                cnt_next    = cnt_reg - CNT_BITS'(1);
            end
            ST_CHECK: begin
                // advance the remainder r*r - x*x at the end of a step
                step_end_next = at_step_end;
                neg_next      = 1'b0;
                if (busy_reg && at_step_end) begin
                    rem_next  = rem_sub;
                    neg_next  = rem_sub[REM_BITS-1];
                    rad_next  = rem_sub[SQ_BITS-1:0];
                    part_next = '0;
                    root_next = '0;
                    cnt_next  = CNT_BITS'(RB - 1);
                end
            end
            ST_ROOT: begin
                // retire one root bit per cycle
                rad_next  = {rad_reg[SQ_BITS-3:0], 2'b00};
                root_next = {root_reg[RB-2:0], root_fits};
                part_next = root_fits ? PART_BITS'(root_shift - root_trial)
                                      : PART_BITS'(root_shift);
                cnt_next  = cnt_reg - CNT_BITS'(1);
            end
            ST_OUT: begin
                // emit the point and move to the next one
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_BITS'({color_reg, py_s[OB-1:0], px_s[OB-1:0]});
                    m_tlast_next  = shape_last;
                    if (step_end_reg) begin
                        idx_next  = '0;
                        x_next    = x_inc;
                        y_next    = {1'b0, root_reg};
                        busy_next = !shape_last;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        r_reg        <= r_next;
        mode_reg     <= mode_next;
        color_reg    <= color_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        mplier_reg   <= mplier_next;
        rad_reg      <= rad_next;
        part_reg     <= part_next;
        root_reg     <= root_next;
        cnt_reg      <= cnt_next;
        step_end_reg <= step_end_next;
        neg_reg      <= neg_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

FILE: src/cor_checker.sv
`default_nettype none

module cor_checker #(
    parameter int M_DATA_BITS = 72
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [M_DATA_BITS-1:0] m_tdata,
    input wire logic                   m_tlast
);

    // Hold a stalled point unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled point changed or dropped");

    // Drop any pending point on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("point pending after reset");

    // Take one request at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // Load a new point only from the busy side of a request
    a_point_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("point appeared without a request in work");

endmodule

bind circle_outline_rasterizer_core cor_checker #(
    .M_DATA_BITS(M_DATA_BITS)
) u_cor_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

`default_nettype wire
